### hdl/gbc_pkg.sv
// Package for the button gesture classifier.
// Holds the per-button entry layout, the result and register types and the register codes.
// No dependencies.
package gbc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_LONG_PRESS    = 2'd0;
  localparam logic [1:0] REG_MIN_SHORT     = 2'd1;
  localparam logic [1:0] REG_LOCKOUT       = 2'd2;
  localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [15:0] LONG_PRESS_RST    = 16'd400;
  localparam logic [15:0] MIN_SHORT_RST     = 16'd10;
  localparam logic [15:0] LOCKOUT_RST       = 16'd500;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd400;

  // Stream widths: 70 payload bits in, 38 out, both padded to whole bytes.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] min_short_ms;
    logic [15:0] lockout_ms;
    logic [15:0] double_window_ms;
  } cfg_t;

  // One row of the per-button table.
  typedef struct packed {
    logic        held;
    logic [31:0] press_start;
    logic        long_active;
    logic [31:0] last_short;
    logic [31:0] press_duration;
  } entry_t;

  typedef struct packed {
    logic        action_due;
    logic [31:0] press_ms;
    logic        double_press;
    logic        short_press;
    logic        released;
    logic        long_end;
    logic        long_start;
  } result_t;

endpackage

### hdl/gbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; a read and a write to one address in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/gbc_core.sv
// Update logic for one button poll: next table row and the result beat.
// Depends on gbc_pkg.
module gbc_core
  import gbc_pkg::*;
(
  input  cfg_t        cfg,
  input  entry_t      entry,
  input  logic        pressed,
  input  logic [31:0] now_ms,
  input  logic        lockout_ok,
  output entry_t      entry_next,
  output result_t     result
);

  logic [31:0] start;
  logic [31:0] held_ms;
  logic [31:0] gap_ms;
  logic [31:0] duration_next;
  logic        long_hit;
  logic        released;
  logic        short_press;

  // The press start is the stored one while held, else this poll's time.
  assign start    = entry.held ? entry.press_start : now_ms;
  assign held_ms  = now_ms - start;
  assign long_hit = held_ms > {16'd0, cfg.long_press_ms};
  assign released = !pressed && entry.held;

  // A release measures the press; an idle release poll clears a stale duration.
  assign duration_next = pressed ? entry.press_duration : (entry.held ? held_ms : 32'd0);

  always_comb begin
    entry_next = entry;
    if (pressed) begin
      entry_next.held        = 1'b1;
      entry_next.press_start = start;
      if (long_hit) begin
        entry_next.long_active = 1'b1;
      end
    end else begin
      entry_next.held        = 1'b0;
      entry_next.long_active = 1'b0;
      entry_next.press_duration = duration_next;
    end
    if (short_press) begin
      entry_next.last_short = now_ms;
    end
  end

  // Short and double press use the duration after this poll's update.
  assign short_press = (duration_next > {16'd0, cfg.min_short_ms}) && lockout_ok;
  assign gap_ms      = now_ms - entry.last_short;

  always_comb begin
    result.long_start   = pressed && long_hit && !entry.long_active;
    result.long_end     = !pressed && entry.long_active;
    result.released     = released;
    result.short_press  = short_press;
    result.double_press = short_press && (gap_ms < {16'd0, cfg.double_window_ms});
    result.press_ms     = entry_next.press_duration;
    result.action_due   = short_press || entry_next.long_active || released;
  end

endmodule

### hdl/button_gesture_classifier.sv
// Top level of the button gesture classifier: stream ports, per-button table and pipeline.
// Depends on gbc_pkg, gbc_ram and gbc_core.
//
// Usage: each beat on the s_ side is one poll of one button. The m_ side returns one
// result beat per poll, in order. Registers are written on the cfg_ channel, which is
// always ready; write them only while no poll is in flight.
//
// Path: the table read and the update stage registers capture an accepted poll, and its
// result then goes into the output register that drives m_tvalid and m_tdata.
// Throughput: one poll per cycle while the receiver does not stall, polls to the same
// button back to back included; the row written by a poll is forwarded to the next one,
// since the RAM read of the next poll happens at the same edge as the write.
//
// Reset clears the pipeline and sets the registers to their defaults. A valid flip-flop
// per button makes untouched rows read as zero, so no clearing pass is needed.
// When the receiver stalls, the output register holds its beat and the update stage
// keeps one more poll; s_tready then drops until m_tready returns.
// A poll naming a button at or above NUM_BUTTONS leaves the table alone and returns
// a beat with all fields zero.
module button_gesture_classifier
  import gbc_pkg::*;
#(
  parameter int NUM_BUTTONS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata, from bit 0: button[4:0], pressed, now_ms[31:0], last_long_action_ms[31:0], 2'b0
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // m_tdata, from bit 0: long_start, long_end, released, short_press, double_press,
  // press_ms[31:0], action_due, 2'b0
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int ENTRY_W = $bits(entry_t);

  cfg_t cfg;

  // Input fields.
  logic [4:0]  in_button;
  logic        in_pressed;
  logic [31:0] in_now;
  logic [31:0] in_last_long;
  logic [IDX_W-1:0] in_idx;
  logic        in_accept;

  assign in_button    = s_tdata[4:0];
  assign in_pressed   = s_tdata[5];
  assign in_now       = s_tdata[37:6];
  assign in_last_long = s_tdata[69:38];
  assign in_idx       = IDX_W'(in_button);

  // Update stage registers.
  logic             s1_valid;
  logic [4:0]       s1_button;
  logic             s1_pressed;
  logic [31:0]      s1_now;
  logic             s1_lockout_ok;
  logic             s1_fwd;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_adv;
  logic             s1_in_range;

  logic [NUM_BUTTONS-1:0] row_valid;
  entry_t fwd_row;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t row;
  entry_t row_next;
  result_t core_result;
  result_t beat;
  logic    wr_en;

  logic              out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  // Handshakes.
  assign s1_adv    = !out_valid || m_tready;
  assign s_tready  = !s1_valid || s1_adv;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign s1_idx      = IDX_W'(s1_button);
  assign s1_in_range = 32'(s1_button) < 32'(NUM_BUTTONS);
  assign wr_en       = s1_valid && s1_adv && s1_in_range;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms    <= LONG_PRESS_RST;
      cfg.min_short_ms     <= MIN_SHORT_RST;
      cfg.lockout_ms       <= LOCKOUT_RST;
      cfg.double_window_ms <= DOUBLE_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_PRESS:    cfg.long_press_ms    <= cfg_data;
        REG_MIN_SHORT:     cfg.min_short_ms     <= cfg_data;
        REG_LOCKOUT:       cfg.lockout_ms       <= cfg_data;
        REG_DOUBLE_WINDOW: cfg.double_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-button table.
  gbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUTTONS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_idx),
    .wdata(row_next),
    .re   (in_accept),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  // Capture a poll; flag it when the row it reads is being written at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
      s1_fwd   <= wr_en && (s1_idx == in_idx);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_button     <= in_button;
      s1_pressed    <= in_pressed;
      s1_now        <= in_now;
      s1_lockout_ok <= (in_now - in_last_long) > {16'd0, cfg.lockout_ms};
    end
  end

  // Row valid bits and the forwarding copy of the last row written.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_row <= row_next;
    end
  end

  // Pick the current row: forwarded, stored, or zero when never written.
  always_comb begin
    if (s1_fwd) begin
      row = fwd_row;
    end else if (row_valid[s1_idx]) begin
      row = entry_t'(ram_rdata);
    end else begin
      row = '0;
    end
  end

  gbc_core u_core (
    .cfg       (cfg),
    .entry     (row),
    .pressed   (s1_pressed),
    .now_ms    (s1_now),
    .lockout_ok(s1_lockout_ok),
    .entry_next(row_next),
    .result    (core_result)
  );

  assign beat = s1_in_range ? core_result : '0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_data <= {2'b00, beat.action_due, beat.press_ms, beat.double_press,
                   beat.short_press, beat.released, beat.long_end, beat.long_start};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### hdl/gbc_checker.sv
// Port-level checks for the button gesture classifier, bound to the top level.
// Depends on gbc_pkg and button_gesture_classifier.
module gbc_checker
  import gbc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present right after reset");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // A double press is always also a short press.
  a_double_short: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3])
    else $error("double press without short press");

  // Short presses and releases always mark an action as due.
  a_action_due: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3] || m_tdata[2]) |-> m_tdata[37])
    else $error("short press or release without action_due");

  // A long press cannot begin and end on the same poll.
  a_long_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("long_start and long_end on one beat");

endmodule

bind button_gesture_classifier gbc_checker u_gbc_checker (.*);

### sim/button_gesture_classifier_tb.sv
// Self-checking testbench for the button gesture classifier.
// Drives polls on the s_ stream, checks every m_ beat against its own gesture predictor.
// Depends on gbc_pkg and button_gesture_classifier.
module button_gesture_classifier_tb;
  import gbc_pkg::*;

  localparam int NUM_BTN = 32;
  localparam int PHASE_POLLS = 370;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  // One poll as it travels in s_tdata, button in the lowest bits.
  typedef struct packed {
    logic [31:0] last_long_ms;
    logic [31:0] now_ms;
    logic        pressed;
    logic [4:0]  button;
  } poll_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Register shadow used by the predictor and the poll generator.
  logic [15:0] lim_long_press    = LONG_PRESS_RST;
  logic [15:0] lim_min_short     = MIN_SHORT_RST;
  logic [15:0] lim_lockout       = LOCKOUT_RST;
  logic [15:0] lim_double_window = DOUBLE_WINDOW_RST;

  // Per-button gesture state of the predictor.
  logic        btn_held     [NUM_BTN];
  logic [31:0] btn_start    [NUM_BTN];
  logic        btn_long     [NUM_BTN];
  logic [31:0] btn_last_tap [NUM_BTN];
  logic [31:0] btn_duration [NUM_BTN];

  poll_t   poll_q[$];
  result_t gesture_due[$];
  poll_t   poll_on_bus;

  int unsigned polls_queued = 0;
  int unsigned polls_accepted = 0;
  int unsigned beats_seen = 0;
  int unsigned fail_cnt = 0;
  int unsigned tx_gap = 0;
  int unsigned tx_gap_max = 3;
  int unsigned rx_wait = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_stall_max = 3;
  int unsigned quiet_cycles = 0;

  logic [31:0] clock_ms = 32'd100;
  logic [4:0]  last_btn = '0;

  always #6 clk = ~clk;

  button_gesture_classifier #(
    .NUM_BUTTONS(NUM_BTN)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Classify one poll and update the per-button state; all time math wraps at 32 bits.
  function automatic result_t predict_gesture(input poll_t p);
    result_t     r;
    logic [4:0]  b;
    logic [31:0] held_ms;
    logic [31:0] since_long;
    logic [31:0] since_tap;
    r = '0;
    b = p.button;
    if (p.pressed) begin
      if (!btn_held[b]) begin
        btn_start[b] = p.now_ms;
        btn_held[b] = 1'b1;
      end
      held_ms = p.now_ms - btn_start[b];
      if (held_ms > {16'd0, lim_long_press}) begin
        r.long_start = !btn_long[b];
        btn_long[b] = 1'b1;
      end
    end else begin
      if (btn_held[b]) begin
        btn_held[b] = 1'b0;
        btn_duration[b] = p.now_ms - btn_start[b];
        r.released = 1'b1;
      end else begin
        btn_duration[b] = '0;
      end
      r.long_end = btn_long[b];
      btn_long[b] = 1'b0;
    end
    // A short press needs a long enough duration and no recent long action.
    since_long = p.now_ms - p.last_long_ms;
    if (btn_duration[b] > {16'd0, lim_min_short} && since_long > {16'd0, lim_lockout}) begin
      since_tap = p.now_ms - btn_last_tap[b];
      r.short_press = 1'b1;
      r.double_press = since_tap < {16'd0, lim_double_window};
      btn_last_tap[b] = p.now_ms;
    end
    r.press_ms = btn_duration[b];
    r.action_due = r.short_press | btn_long[b] | r.released;
    return r;
  endfunction

  task automatic queue_poll(input logic [4:0] b, input logic down, input logic [31:0] now,
                            input logic [31:0] last_long);
    poll_t p;
    p.button = b;
    p.pressed = down;
    p.now_ms = now;
    p.last_long_ms = last_long;
    poll_q.push_back(p);
    polls_queued++;
  endtask

  // Long-action time inside, at the edge of, or far from the lockout window.
  function automatic logic [31:0] pick_last_long(input logic [31:0] t);
    case ($urandom_range(0, 2))
      0: return t - $urandom_range(0, lim_lockout + 2);
      1: return t - lim_lockout - 1 - $urandom_range(0, 4000);
      default: return $urandom;
    endcase
  endfunction

  // One press-hold-release run on a mostly repeated button, or a stray poll.
  task automatic queue_gesture();
    logic [4:0]  b;
    logic [31:0] t0;
    int unsigned dur;
    int unsigned mids;
    if ($urandom_range(0, 9) < 7) b = last_btn;
    else b = 5'($urandom_range(0, NUM_BTN - 1));
    last_btn = b;
    case ($urandom_range(0, 11))
      0: begin
        // Fully random poll.
        queue_poll(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), $urandom, $urandom);
        return;
      end
      1: begin
        // Release poll while not held clears a stale duration.
        queue_poll(b, 1'b0, clock_ms, pick_last_long(clock_ms));
        clock_ms = clock_ms + $urandom_range(0, 300);
        return;
      end
      2: begin
        queue_poll(b, 1'b1, clock_ms, pick_last_long(clock_ms));
        clock_ms = clock_ms + $urandom_range(0, 300);
        return;
      end
      3: dur = $urandom_range(0, lim_min_short + 2);
      4, 5: dur = $urandom_range(lim_long_press > 2 ? lim_long_press - 2 : 0,
                                 lim_long_press + 2);
      6, 7, 8: dur = $urandom_range(lim_min_short, lim_long_press);
      default: dur = $urandom_range(0, 2 * lim_long_press + 1000);
    endcase
    t0 = clock_ms;
    queue_poll(b, 1'b1, t0, pick_last_long(t0));
    mids = $urandom_range(0, 3);
    repeat (mids) queue_poll(b, 1'b1, t0 + $urandom_range(0, dur), pick_last_long(t0 + dur));
    queue_poll(b, 1'b0, t0 + dur, pick_last_long(t0 + dur));
    // Now and then jump close to the top so the time base wraps.
    if ($urandom_range(0, 39) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else clock_ms = t0 + dur + $urandom_range(0, lim_double_window + 100);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LONG_PRESS: lim_long_press = val;
      REG_MIN_SHORT: lim_min_short = val;
      REG_LOCKOUT: lim_lockout = val;
      REG_DOUBLE_WINDOW: lim_double_window = val;
      default: ;
    endcase
  endtask

  // Wait until every queued poll is accepted and its result has come back.
  task automatic wait_drained();
    while (polls_accepted != polls_queued || gesture_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: offers polls from the queue with a random gap after each accepted beat.
  always @(posedge clk) begin : drive
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        gesture_due.push_back(predict_gesture(poll_on_bus));
        polls_accepted++;
        tx_gap = $urandom_range(0, tx_gap_max);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (poll_q.size() != 0) begin
          poll_on_bus = poll_q.pop_front();
          s_tdata <= {2'b00, poll_on_bus};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat, then stalls at random or for a long hold-off.
  always @(posedge clk) begin : receive
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[37:0]);
        beats_seen++;
        if (gesture_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("beat %0d arrived with no poll pending", beats_seen);
        end else begin
          want = gesture_due.pop_front();
          if (got.long_start !== want.long_start || got.long_end !== want.long_end ||
              got.released !== want.released || got.short_press !== want.short_press ||
              got.double_press !== want.double_press || got.press_ms !== want.press_ms ||
              got.action_due !== want.action_due) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("beat %0d: expected ls=%0b le=%0b rel=%0b sp=%0b dp=%0b ms=%0d due=%0b",
                       beats_seen, want.long_start, want.long_end, want.released,
                       want.short_press, want.double_press, want.press_ms, want.action_due,
                       "\n  actual ls=%0b le=%0b rel=%0b sp=%0b dp=%0b ms=%0d due=%0b",
                       got.long_start, got.long_end, got.released, got.short_press,
                       got.double_press, got.press_ms, got.action_due);
          end
        end
        rx_wait = $urandom_range(0, rx_stall_max);
        // Long hold-off so the pipeline fills and s_tready drops.
        if (beats_seen == 500 || beats_seen == 1400) rx_hold = HOLD_CYCLES;
      end else if (rx_hold != 0) begin
        rx_hold--;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_tready <= (rx_hold == 0 && rx_wait == 0);
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] lp [5];
    logic [15:0] ms [5];
    logic [15:0] lo [5];
    logic [15:0] dw [5];
    int unsigned txm [5];
    int unsigned rxm [5];
    int unsigned first;
    lp = '{16'd400, 16'd0, 16'hFFFF, 16'd50, 16'd0};
    ms = '{16'd10, 16'd0, 16'hFFFF, 16'd5, 16'd0};
    lo = '{16'd500, 16'd0, 16'hFFFF, 16'd20, 16'd0};
    dw = '{16'd400, 16'd0, 16'hFFFF, 16'd150, 16'd0};
    txm = '{3, 0, 3, 3, 0};
    rxm = '{3, 0, 3, 0, 3};
    lp[4] = 16'($urandom_range(0, 2000));
    ms[4] = 16'($urandom_range(0, 200));
    lo[4] = 16'($urandom_range(0, 3000));
    dw[4] = 16'($urandom_range(0, 1000));
    for (int i = 0; i < NUM_BTN; i++) begin
      btn_held[i] = 1'b0;
      btn_start[i] = '0;
      btn_long[i] = 1'b0;
      btn_last_tap[i] = '0;
      btn_duration[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed polls at reset settings.
    // Press at the top of the time base, release after the wrap inside the lockout.
    queue_poll(5'd31, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_poll(5'd31, 1'b0, 32'h0000_0180, 32'd0);
    queue_poll(5'd0, 1'b0, 32'd0, 32'd0);
    // Duration equal to the short minimum is not a short press.
    queue_poll(5'd1, 1'b1, 32'd1000, 32'd0);
    queue_poll(5'd1, 1'b0, 32'd1010, 32'd0);
    // Short press, then the stale duration repeats it on the next pressed poll.
    queue_poll(5'd1, 1'b1, 32'd2000, 32'd0);
    queue_poll(5'd1, 1'b0, 32'd2050, 32'd0);
    queue_poll(5'd1, 1'b1, 32'd2100, 32'd0);
    // Gap equal to the double window is not a double press.
    queue_poll(5'd1, 1'b0, 32'd2500, 32'd0);
    // Idle release clears the stale duration.
    queue_poll(5'd1, 1'b0, 32'd2600, 32'd0);
    // Time since the long action equal to the lockout suppresses the short press.
    queue_poll(5'd1, 1'b1, 32'd2700, 32'd0);
    queue_poll(5'd1, 1'b0, 32'd2720, 32'd2220);
    // Short press inside the double window.
    queue_poll(5'd1, 1'b1, 32'd2800, 32'd2220);
    queue_poll(5'd1, 1'b0, 32'd2830, 32'd2229);
    // Long press: threshold exactly, one past, held on, released inside the lockout.
    queue_poll(5'd2, 1'b1, 32'd5000, 32'd0);
    queue_poll(5'd2, 1'b1, 32'd5400, 32'd0);
    queue_poll(5'd2, 1'b1, 32'd5401, 32'd0);
    queue_poll(5'd2, 1'b1, 32'd6000, 32'd0);
    queue_poll(5'd2, 1'b0, 32'd6100, 32'd5800);
    queue_poll(5'd2, 1'b0, 32'd6200, 32'd5800);
    // Alternating bit patterns on every field.
    queue_poll(5'd30, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_poll(5'd30, 1'b0, 32'h8000_0100, 32'd0);
    queue_poll(5'd16, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_poll(5'd16, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_poll(5'd21, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();

    // Random phases, each with its own register setting and an idling pattern.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_LONG_PRESS, lp[ph]);
      write_reg(REG_MIN_SHORT, ms[ph]);
      write_reg(REG_LOCKOUT, lo[ph]);
      write_reg(REG_DOUBLE_WINDOW, dw[ph]);
      tx_gap_max = txm[ph];
      rx_stall_max = rxm[ph];
      first = polls_queued;
      while (polls_queued - first < PHASE_POLLS) queue_gesture();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && gesture_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
